// ===== sv/tml_pkg.sv =====
// ---------------------------------------------------------------------------
// tml_pkg: template macro lexer types, codes and per-character step logic
// Shared by the lexer top level; holds the mode codes and the step function.
// ---------------------------------------------------------------------------
`default_nettype none
package tml_pkg;

   localparam int OffsetBits = 32;
   localparam int NestBits   = 16;
   localparam int MaxRsp     = 4;
   localparam int FifoDepth  = 8;
   localparam int PtrBits    = $clog2(FifoDepth);

   typedef logic [OffsetBits-1:0] off_type;
   typedef logic [NestBits-1:0]   nest_type;

   // token kinds
   localparam logic [3:0] K_DOC    = 4'd0;
   localparam logic [3:0] K_EOF    = 4'd1;
   localparam logic [3:0] K_DOLLAR = 4'd2;
   localparam logic [3:0] K_BLOCK  = 4'd3;
   localparam logic [3:0] K_INLINE = 4'd4;
   localparam logic [3:0] K_LINE   = 4'd5;
   localparam logic [3:0] K_SYM    = 4'd6;
   localparam logic [3:0] K_IMM    = 4'd7;
   localparam logic [3:0] K_IDENT  = 4'd8;
   localparam logic [3:0] K_METHOD = 4'd9;
   localparam logic [3:0] K_TUPLE  = 4'd10;
   localparam logic [3:0] K_STRING = 4'd11;

   // error codes
   localparam logic [2:0] E_NONE      = 3'd0;
   localparam logic [2:0] E_BLOCK     = 3'd1;
   localparam logic [2:0] E_DOLLAR    = 3'd2;
   localparam logic [2:0] E_INLINE    = 3'd3;
   localparam logic [2:0] E_NO_IDENT  = 3'd4;
   localparam logic [2:0] E_DOT       = 3'd5;
   localparam logic [2:0] E_ARGS      = 3'd6;
   localparam logic [2:0] E_STRING    = 3'd7;

   // lexer modes
   localparam logic [4:0] M_DOC          = 5'd0;
   localparam logic [4:0] M_DOLLAR1      = 5'd1;
   localparam logic [4:0] M_DOLLAR2      = 5'd2;
   localparam logic [4:0] M_LINE         = 5'd3;
   localparam logic [4:0] M_BLOCK_FIRST  = 5'd4;
   localparam logic [4:0] M_BLOCK        = 5'd5;
   localparam logic [4:0] M_INLINE_FIRST = 5'd6;
   localparam logic [4:0] M_INLINE       = 5'd7;
   localparam logic [4:0] M_AT1          = 5'd8;
   localparam logic [4:0] M_AT2          = 5'd9;
   localparam logic [4:0] M_MAC_WS       = 5'd10;
   localparam logic [4:0] M_IDENT        = 5'd11;
   localparam logic [4:0] M_COLON        = 5'd12;
   localparam logic [4:0] M_METHOD       = 5'd13;
   localparam logic [4:0] M_ARG_WS       = 5'd14;
   localparam logic [4:0] M_TUP_WS0      = 5'd15;
   localparam logic [4:0] M_TUP          = 5'd16;
   localparam logic [4:0] M_STR_FIRST    = 5'd17;
   localparam logic [4:0] M_STR          = 5'd18;
   localparam logic [4:0] M_DONE         = 5'd19;

   localparam logic [20:0] C_NL     = 21'h0A;
   localparam logic [20:0] C_QUOTE  = 21'h22;
   localparam logic [20:0] C_DOLLAR = 21'h24;
   localparam logic [20:0] C_LPAR   = 21'h28;
   localparam logic [20:0] C_RPAR   = 21'h29;
   localparam logic [20:0] C_COMMA  = 21'h2C;
   localparam logic [20:0] C_DOT    = 21'h2E;
   localparam logic [20:0] C_COLON  = 21'h3A;
   localparam logic [20:0] C_AT     = 21'h40;
   localparam logic [20:0] C_USCORE = 21'h5F;
   localparam logic [20:0] C_LBRACE = 21'h7B;
   localparam logic [20:0] C_RBRACE = 21'h7D;

   typedef struct packed {
      logic [20:0] codepoint;
      logic [2:0]  byte_len;
      logic        end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [31:0] token_start;
      logic [31:0] token_length;
      logic [31:0] indent_start;
      logic [31:0] indent_length;
      logic [31:0] colon_offset;
      logic [2:0]  error_code;
      logic        is_last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] mode;
      off_type    tok_begin;
      off_type    space_start;
      off_type    space_count;
      nest_type   paren;
      nest_type   brace;
      off_type    held_start;
      off_type    held_len;
      logic [1:0] dollar_run;
      logic       body;
      off_type    colon_pos;
      logic       fresh;
   } lex_state_type;

   typedef struct packed {
      lex_state_type     st;
      logic              again;
      logic [2:0]        n;
      rsp_type [MaxRsp-1:0] res;
   } lex_ctx_type;

   function automatic logic is_ws(input logic [20:0] c);
      return c inside {[21'd9:21'd13], 21'd32};
   endfunction

   function automatic logic is_first(input logic [20:0] c);
      return c inside {[21'h61:21'h7A], [21'h41:21'h5A], C_USCORE};
   endfunction

   function automatic logic is_ident(input logic [20:0] c);
      return is_first(c) || (c inside {[21'h30:21'h39]});
   endfunction

   function automatic nest_type sat_inc(input nest_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic lex_ctx_type put(input lex_ctx_type x, input logic [3:0] kind,
                                       input off_type start, input off_type len,
                                       input off_type ist, input off_type ilen,
                                       input off_type colon, input logic [2:0] err);
      lex_ctx_type y;
      rsp_type r;
      y = x;
      r.token_kind    = kind;
      r.token_start   = 32'(start);
      r.token_length  = 32'(len);
      r.indent_start  = 32'(ist);
      r.indent_length = 32'(ilen);
      r.colon_offset  = 32'(colon);
      r.error_code    = err;
      r.is_last       = 1'b0;
      if (x.n < 3'(MaxRsp)) begin
         y.res[x.n[1:0]] = r;
         y.n = x.n + 3'd1;
      end
      return y;
   endfunction

   function automatic lex_ctx_type tok(input lex_ctx_type x, input logic [3:0] kind,
                                       input off_type start, input off_type len);
      if (len != '0) return put(x, kind, start, len, '0, '0, '0, E_NONE);
      return x;
   endfunction

   function automatic lex_ctx_type fail(input lex_ctx_type x, input logic [2:0] code,
                                        input off_type loc);
      lex_ctx_type y;
      y = put(x, K_EOF, loc, off_type'(1), '0, '0, '0, code);
      y.st.mode = M_DONE;
      return y;
   endfunction

   function automatic lex_ctx_type enter_doc(input lex_ctx_type x, input off_type at);
      lex_ctx_type y;
      y = x;
      y.st.tok_begin   = at;
      y.st.body        = 1'b0;
      y.st.space_start = '0;
      y.st.space_count = '0;
      y.st.mode        = M_DOC;
      return y;
   endfunction

   // One pass of the mode logic; again requests another pass on the same char.
   function automatic lex_ctx_type lex_step(input lex_ctx_type x, input logic [20:0] c,
                                            input logic [2:0] blen, input logic eof,
                                            input off_type off, input off_type nxt);
      lex_ctx_type y;
      off_type     l;
      off_type     hl;
      logic [1:0]  dr;
      y = x;
      y.again = 1'b0;
      l  = off - x.st.tok_begin;
      hl = x.st.held_len;
      dr = x.st.dollar_run + 2'd1;
      case (x.st.mode)
         M_DOC: begin
            if (eof) begin
               y = tok(y, K_DOC, x.st.tok_begin, l);
               y = tok(y, K_EOF, off, off_type'(1));
               y.st.mode = M_DONE;
            end else if (c == C_AT) begin
               y = tok(y, K_DOC, x.st.tok_begin, l);
               if (!x.st.body) begin
                  y.st.space_start = '0;
                  y.st.space_count = '0;
               end
               y.st.tok_begin = off;
               y.st.mode = M_AT1;
            end else if (c == C_DOLLAR) begin
               y.st.held_start = x.st.tok_begin;
               y.st.held_len   = l;
               y.st.tok_begin  = off;
               y.st.mode = M_DOLLAR1;
            end else if (is_ws(c) && c != C_NL) begin
               if (x.st.space_count == '0) begin
                  y.st.space_start = off;
                  y.st.space_count = off_type'(blen);
               end else begin
                  y.st.space_count = x.st.space_count + off_type'(blen);
               end
            end else begin
               if (!is_ws(c)) y.st.body = 1'b1;
               y.st.space_start = '0;
               y.st.space_count = '0;
            end
         end
         M_DOLLAR1: begin
            if (c != C_DOLLAR && c != C_LPAR)
               hl = (hl > x.st.space_count) ? hl - x.st.space_count : '0;
            y = tok(y, K_DOC, x.st.held_start, hl);
            y = tok(y, K_DOLLAR, x.st.tok_begin, l);
            y.st.held_start = '0;
            y.st.held_len   = '0;
            if (c == C_DOLLAR) begin
               y.st.mode = M_DOLLAR2;
            end else if (c == C_LPAR) begin
               y.st.tok_begin = nxt;
               y.st.mode = M_INLINE_FIRST;
            end else begin
               y.st.tok_begin = off;
               y.st.mode = M_LINE;
               y.again = 1'b1;
            end
         end
         M_LINE: begin
            if (eof) begin
               y = tok(y, K_LINE, x.st.tok_begin, l);
               y = tok(y, K_EOF, off, off_type'(1));
               y.st.mode = M_DONE;
            end else if (c == C_NL) begin
               y = tok(y, K_LINE, x.st.tok_begin, l);
               y = enter_doc(y, nxt);
            end
         end
         M_DOLLAR2: begin
            if (c == C_DOLLAR) begin
               y.st.tok_begin = nxt;
               y.st.mode = M_BLOCK_FIRST;
            end else begin
               y = fail(y, E_DOLLAR, off);
            end
         end
         M_BLOCK_FIRST: begin
            if (eof) y = fail(y, E_BLOCK, x.st.tok_begin);
            else begin
               y.st.dollar_run = '0;
               y.st.mode = M_BLOCK;
            end
         end
         M_BLOCK: begin
            if (c == C_DOLLAR) begin
               y.st.dollar_run = dr;
               if (dr == 2'd3) begin
                  l = nxt - x.st.tok_begin;
                  if (l > off_type'(3)) y = tok(y, K_BLOCK, x.st.tok_begin, l - off_type'(3));
                  y = enter_doc(y, nxt);
               end
            end else if (eof) begin
               y = fail(y, E_BLOCK, x.st.tok_begin);
            end else begin
               y.st.dollar_run = '0;
            end
         end
         M_INLINE_FIRST: begin
            if (eof) y = fail(y, E_INLINE, x.st.tok_begin);
            else begin
               y.st.paren = nest_type'(1);
               y.st.mode = M_INLINE;
            end
         end
         M_INLINE: begin
            if (eof) begin
               y = fail(y, E_INLINE, x.st.tok_begin);
            end else if (c == C_LPAR) begin
               y.st.paren = sat_inc(x.st.paren);
            end else if (c == C_RPAR) begin
               if (x.st.paren <= nest_type'(1)) begin
                  y = tok(y, K_INLINE, x.st.tok_begin, l);
                  y = enter_doc(y, nxt);
               end else begin
                  y.st.paren = x.st.paren - 1'b1;
               end
            end
         end
         M_AT1, M_AT2: begin
            if (x.st.mode == M_AT1 && c == C_AT) begin
               y.st.mode = M_AT2;
            end else begin
               if (l != '0)
                  y = put(y, (x.st.mode == M_AT1) ? K_SYM : K_IMM, x.st.tok_begin, l,
                          x.st.space_start, x.st.space_count, '0, E_NONE);
               y.st.mode = M_MAC_WS;
               y.again = 1'b1;
            end
         end
         M_MAC_WS: begin
            if (!is_ws(c)) begin
               y.st.tok_begin = off;
               if (!is_first(c)) y = fail(y, E_NO_IDENT, off);
               else y.st.mode = M_IDENT;
            end
         end
         M_IDENT: begin
            if (c == C_COLON) begin
               y.st.colon_pos = off;
               y.st.mode = M_COLON;
            end else if (!(is_ident(c) || c == C_DOT)) begin
               y = tok(y, K_IDENT, x.st.tok_begin, l);
               y.st.mode = M_ARG_WS;
               y.again = 1'b1;
            end
         end
         M_COLON: begin
            if (is_first(c)) begin
               y.st.mode = M_METHOD;
            end else begin
               y = tok(y, K_IDENT, x.st.tok_begin, x.st.colon_pos - x.st.tok_begin);
               y = enter_doc(y, x.st.colon_pos);
               y.st.body = 1'b1;
               y.again = 1'b1;
            end
         end
         M_METHOD: begin
            if (is_ident(c)) begin
               y.st.mode = M_METHOD;
            end else if (c == C_DOT || c == C_COLON) begin
               y = fail(y, E_DOT, off);
            end else begin
               if (l != '0)
                  y = put(y, K_METHOD, x.st.tok_begin, l, '0, '0,
                          x.st.colon_pos - x.st.tok_begin, E_NONE);
               y.st.mode = M_ARG_WS;
               y.again = 1'b1;
            end
         end
         M_ARG_WS: begin
            if (!is_ws(c)) begin
               if (c == C_LPAR) y.st.mode = M_TUP_WS0;
               else if (c == C_QUOTE) y.st.mode = M_STR_FIRST;
               else begin
                  y = enter_doc(y, off);
                  y.again = 1'b1;
               end
            end
         end
         M_TUP_WS0: begin
            if (!is_ws(c)) begin
               if (c == C_RPAR) y = enter_doc(y, nxt);
               else begin
                  y.st.brace = '0;
                  y.st.paren = nest_type'(1);
                  y.st.tok_begin = off;
                  y.st.fresh = 1'b0;
                  y.st.mode = M_TUP;
                  y.again = 1'b1;
               end
            end
         end
         M_TUP: begin
            if (!(x.st.fresh && is_ws(c))) begin
               if (x.st.fresh) begin
                  y.st.tok_begin = off;
                  y.st.fresh = 1'b0;
                  l = '0;
               end
               if (eof) begin
                  y = fail(y, E_ARGS, y.st.tok_begin);
               end else if (c == C_COMMA) begin
                  if (x.st.brace == '0 && x.st.paren == nest_type'(1)) begin
                     y = tok(y, K_TUPLE, y.st.tok_begin, l);
                     y.st.fresh = 1'b1;
                  end
               end else if (c == C_LPAR) begin
                  y.st.paren = sat_inc(x.st.paren);
               end else if (c == C_RPAR) begin
                  if (x.st.paren <= nest_type'(1)) begin
                     y = tok(y, K_TUPLE, y.st.tok_begin, l);
                     y = enter_doc(y, nxt);
                  end else begin
                     y.st.paren = x.st.paren - 1'b1;
                  end
               end else if (c == C_LBRACE) begin
                  y.st.brace = sat_inc(x.st.brace);
               end else if (c == C_RBRACE) begin
                  if (x.st.brace != '0) y.st.brace = x.st.brace - 1'b1;
               end
            end
         end
         M_STR_FIRST: begin
            y.st.tok_begin = off;
            if (eof) y = fail(y, E_STRING, off);
            else y.st.mode = M_STR;
         end
         M_STR: begin
            if (eof) begin
               y = fail(y, E_STRING, x.st.tok_begin);
            end else if (c == C_QUOTE) begin
               y = tok(y, K_STRING, x.st.tok_begin, l);
               y = enter_doc(y, nxt);
            end
         end
         default: y.st.mode = M_DONE;
      endcase
      return y;
   endfunction

endpackage
`default_nettype wire

// ===== sv/template_macro_lexer_top.sv =====
// ---------------------------------------------------------------------------
// template_macro_lexer_top: template and macro source lexer
// Splits a codepoint stream into document, lua and macro tokens.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one decoded codepoint per request (codepoint, byte_len,
//   end_of_input). rsp_* returns tokens (kind, start, length, indent, colon
//   offset, error code), is_last marking the final token a request caused.
//   A request causes zero to four tokens. The mode logic runs in the cycle
//   the request is taken and pushes its tokens into an 8-entry result queue;
//   the first token is visible on rsp_* the next cycle.
//   Throughput is one request per cycle while the queue has room for four
//   tokens; draining is one token per cycle, so the rsp side port sets the
//   sustained rate when requests yield more than one token each.
//   When the receiver stalls, tokens wait in the queue and req_ready drops
//   once fewer than four slots are free.
//   After an eof token or an error the lexer ignores further requests.
//   Reset (synchronous) empties the queue and returns to document mode at
//   byte offset zero.
// ---------------------------------------------------------------------------
`default_nettype none
module template_macro_lexer_top
   import tml_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   lex_state_type state_ff, state_in;
   off_type       offset_ff, offset_in;
   rsp_type       fifo_ff [FifoDepth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]   count_ff, count_in;

   lex_ctx_type ctx;
   logic        accept, pop, eof;
   logic [20:0] c;
   off_type     nxt;

   assign req_ready = (count_ff <= (PtrBits+1)'(FifoDepth - MaxRsp));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   assign eof = req_data.end_of_input || (req_data.codepoint == '0);
   assign c   = eof ? '0 : req_data.codepoint;
   assign nxt = offset_ff + off_type'(req_data.byte_len);

   always_comb begin
      ctx = '0;
      ctx.st = state_ff;
      ctx.again = 1'b1;
      // at most three mode passes per character
      for (int p = 0; p < 3; p++) begin
         if (ctx.again && ctx.st.mode != M_DONE)
            ctx = lex_step(ctx, c, req_data.byte_len, eof, offset_ff, nxt);
      end
      if (ctx.n != '0) ctx.res[2'(ctx.n - 3'd1)].is_last = 1'b1;
   end

   always_comb begin
      state_in  = state_ff;
      offset_in = offset_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         state_in  = ctx.st;
         offset_in = nxt;
         wr_ptr_in = wr_ptr_ff + PtrBits'(ctx.n);
         count_in  = count_in + (PtrBits+1)'(ctx.n);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         offset_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxRsp; k++) begin
         if (accept && 3'(k) < ctx.n)
            fifo_ff[PtrBits'(wr_ptr_ff + PtrBits'(k))] <= ctx.res[k];
      end
   end

endmodule
`default_nettype wire
